// File: sv/deq_pkg.sv
package deq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned WORD_W = 32;

    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int unsigned CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_HOLD       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [WORD_W-1:0] value;
    } deq_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] front_word;
        logic signed [WORD_W-1:0] back_word;
        logic [4:0]               occupancy;
        logic [1:0]               status;
    } deq_out_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } cell_link_t;

endpackage

// File: sv/deq_cell.sv
module deq_cell import deq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [WORD_W-1:0] value_i,
    input  cell_link_t        left_i,
    input  cell_link_t        right_i,
    output cell_link_t        cell_o
);

    logic              valid_reg, valid_next;
    logic [WORD_W-1:0] word_reg, word_next;

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        unique case (cmd)
            CMD_PUSH_FRONT: begin
                valid_next = left_i.valid;
                word_next  = left_i.word;
            end
            CMD_POP_FRONT: begin
                valid_next = right_i.valid;
                word_next  = right_i.word;
            end
            CMD_PUSH_BACK: begin
                // first free cell takes the item
                if (!valid_reg && left_i.valid) begin
                    valid_next = 1'b1;
                    word_next  = value_i;
                end
            end
            CMD_POP_BACK: begin
                if (valid_reg && !right_i.valid) begin
                    valid_next = 1'b0;
                end
            end
            default: begin
                valid_next = valid_reg;
                word_next  = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign cell_o.valid = valid_reg;
    assign cell_o.word  = word_reg;

endmodule

// File: sv/deq_tree.sv
module deq_tree import deq_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic [WORD_W-1:0] leaf_i [DEPTH],
    output logic [WORD_W-1:0] root_o
);

    localparam int unsigned LEVELS = $clog2(DEPTH);
    localparam int unsigned LEAVES = 1 << LEVELS;

    logic [WORD_W-1:0] leaf_pad [LEAVES];
    logic [WORD_W-1:0] node_reg [1:LEAVES-1];

    for (genvar i = 0; i < LEAVES; i++) begin : g_pad
        if (i < DEPTH) begin : g_used
            assign leaf_pad[i] = leaf_i[i];
        end else begin : g_spare
            assign leaf_pad[i] = '0;
        end
    end

    // each or-level is registered, at most one leaf is non-zero
    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        if (2 * n >= LEAVES) begin : g_bottom
            always_ff @(posedge aclk) begin
                node_reg[n] <= leaf_pad[2*n-LEAVES] | leaf_pad[2*n+1-LEAVES];
            end
        end else begin : g_inner
            always_ff @(posedge aclk) begin
                node_reg[n] <= node_reg[2*n] | node_reg[2*n+1];
            end
        end
    end

    assign root_o = node_reg[1];

endmodule

// File: sv/double_ended_queue.sv
// channel  | ports                      | payload
// ---------+----------------------------+-----------------------------------------
// input    | s_valid, s_ready, s_item   | opcode, value
// result   | m_valid, m_ready, m_item   | front_word, back_word, occupancy, status
//
// per item: the cell row shifts, the registered or-tree finds the back word, then the
// result register loads once the output is free; no new item is taken until then
// aresetn is synchronous and active low, the queue is empty after reset
// a result held by m_ready low does not block the next accepted item's work
module double_ended_queue import deq_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  deq_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_out_t m_item
);

    localparam int unsigned CW     = $clog2(DEPTH + 1);
    localparam int unsigned LEVELS = $clog2(DEPTH);
    localparam int unsigned WW     = $clog2(LEVELS + 1);

    localparam logic STATE_IDLE   = 1'b0;
    localparam logic STATE_SETTLE = 1'b1;

    logic              state_reg, state_next;
    logic [WW-1:0]     wait_reg, wait_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [1:0]        status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    deq_out_t          m_item_reg, m_item_next;

    logic [CMD_W-1:0]  cell_cmd;
    logic [1:0]        op_status;
    logic [CW-1:0]     op_count;
    logic              accept;
    logic              full, empty;
    logic              load;
    logic [CW+4:0]     occ_wide;

    cell_link_t        cells      [DEPTH];
    cell_link_t        left_link  [DEPTH];
    cell_link_t        right_link [DEPTH];
    logic [WORD_W-1:0] leaf       [DEPTH];
    logic [WORD_W-1:0] back_word;
    logic [DEPTH-1:0]  valid_vec;

    assign accept = s_valid && s_ready;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    always_comb begin
        cell_cmd  = CMD_HOLD;
        op_status = ST_OK;
        op_count  = count_reg;
        unique case (s_item.opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (full) begin
                    op_status = ST_FULL;
                end else begin
                    cell_cmd = (s_item.opcode == OP_PUSH_BACK) ? CMD_PUSH_BACK
                                                                : CMD_PUSH_FRONT;
                    op_count = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (empty) begin
                    op_status = ST_EMPTY;
                end else begin
                    cell_cmd = (s_item.opcode == OP_POP_FRONT) ? CMD_POP_FRONT
                                                               : CMD_POP_BACK;
                    op_count = count_reg - 1'b1;
                end
            end
            default: begin
                cell_cmd  = CMD_HOLD;
                op_status = ST_OK;
                op_count  = count_reg;
            end
        endcase
        if (!accept) begin
            cell_cmd = CMD_HOLD;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign left_link[i].valid = 1'b1;
            assign left_link[i].word  = s_item.value;
        end else begin : g_body
            assign left_link[i] = cells[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_link[i] = '0;
        end else begin : g_inner
            assign right_link[i] = cells[i+1];
        end

        deq_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cell_cmd),
            .value_i (s_item.value),
            .left_i  (left_link[i]),
            .right_i (right_link[i]),
            .cell_o  (cells[i])
        );

        assign leaf[i] = (cells[i].valid && !right_link[i].valid) ? cells[i].word : '0;
        assign valid_vec[i] = cells[i].valid;
    end

    deq_tree #(
        .DEPTH (DEPTH)
    ) u_tree (
        .aclk   (aclk),
        .leaf_i (leaf),
        .root_o (back_word)
    );

    assign occ_wide = {5'd0, count_reg};
    assign load     = (state_reg == STATE_SETTLE) && (wait_reg == '0)
                      && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        wait_next    = wait_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            STATE_IDLE: begin
                if (accept) begin
                    state_next  = STATE_SETTLE;
                    wait_next   = WW'(LEVELS);
                    count_next  = op_count;
                    status_next = op_status;
                end
            end
            STATE_SETTLE: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else if (load) begin
                    state_next             = STATE_IDLE;
                    m_valid_next           = 1'b1;
                    m_item_next.front_word = cells[0].valid ? cells[0].word : '0;
                    m_item_next.back_word  = back_word;
                    m_item_next.occupancy  = occ_wide[4:0];
                    m_item_next.status     = status_reg;
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_IDLE;
            wait_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        m_item_reg <= m_item_next;
    end

    assign s_ready = (state_reg == STATE_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("count beyond depth");

    a_cells_match_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell valid bits disagree with count");

    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cells[0].valid == (count_reg != '0))
        else $error("head cell validity disagrees with count");

    a_empty_pop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && empty && (s_item.opcode == OP_POP_FRONT || s_item.opcode == OP_POP_BACK)
        |=> (count_reg == '0) && (status_reg == ST_EMPTY))
        else $error("pop on empty queue changed state");

endmodule

// File: sim/deque_checker.sv
module deque_checker import deq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  deq_in_t  s_item,
    input  logic     m_valid,
    input  logic     m_ready,
    input  deq_out_t m_item,
    output int       mismatches,
    output int       views_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = DEPTH_DEFAULT;
    localparam int IDX_W = $clog2(SLOTS);

    logic [WORD_W-1:0] ring [SLOTS];
    logic [IDX_W-1:0]  head;
    logic [IDX_W-1:0]  tail;
    logic [4:0]        held;
    deq_out_t          expected_views [$];

    // head is the front slot, tail is one past the back slot
    function automatic deq_out_t apply_op(deq_in_t it);
        deq_out_t         view;
        logic [IDX_W-1:0] last;
        logic             full_now;
        logic             empty_now;
        full_now = (held == SLOTS);
        empty_now = (held == 0);
        view.status = ST_OK;
        case (it.opcode)
            OP_PUSH_BACK: begin
                if (full_now) begin
                    view.status = ST_FULL;
                end else begin
                    ring[tail] = it.value;
                    tail = tail + 1'b1;
                    held = held + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (full_now) begin
                    view.status = ST_FULL;
                end else begin
                    head = head - 1'b1;
                    ring[head] = it.value;
                    held = held + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty_now) begin
                    view.status = ST_EMPTY;
                end else begin
                    head = head + 1'b1;
                    held = held - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty_now) begin
                    view.status = ST_EMPTY;
                end else begin
                    tail = tail - 1'b1;
                    held = held - 1'b1;
                end
            end
            default: begin
            end
        endcase
        view.occupancy = held;
        if (held == 0) begin
            view.front_word = '0;
            view.back_word = '0;
        end else begin
            last = tail - 1'b1;
            view.front_word = ring[head];
            view.back_word = ring[last];
        end
        return view;
    endfunction

    always @(posedge aclk) begin
        deq_out_t want;
        int       errs;
        errs = 0;
        if (!aresetn) begin
            head = '0;
            tail = '0;
            held = '0;
            expected_views.delete();
            mismatches <= 0;
            views_pending <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_views.push_back(apply_op(s_item));
            end
            if (m_valid && m_ready) begin
                if (expected_views.size() == 0) begin
                    $display("%0t unexpected item: front %0d back %0d occupancy %0d status %0d",
                             $time, m_item.front_word, m_item.back_word,
                             m_item.occupancy, m_item.status);
                    errs++;
                end else begin
                    want = expected_views.pop_front();
                    if (m_item.front_word !== want.front_word) begin
                        $display("%0t front_word expected %0d actual %0d",
                                 $time, want.front_word, m_item.front_word);
                        errs++;
                    end
                    if (m_item.back_word !== want.back_word) begin
                        $display("%0t back_word expected %0d actual %0d",
                                 $time, want.back_word, m_item.back_word);
                        errs++;
                    end
                    if (m_item.occupancy !== want.occupancy) begin
                        $display("%0t occupancy expected %0d actual %0d",
                                 $time, want.occupancy, m_item.occupancy);
                        errs++;
                    end
                    if (m_item.status !== want.status) begin
                        $display("%0t status expected %0d actual %0d",
                                 $time, want.status, m_item.status);
                        errs++;
                    end
                end
            end
            mismatches <= mismatches + errs;
            views_pending <= expected_views.size();
        end
    end

endmodule

// File: sim/testbench.sv
module testbench import deq_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS = 1900;
    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    deq_in_t  s_item = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    deq_out_t m_item;
    int       mismatches;
    int       views_pending;

    bit       tx_calm = 1'b0;
    bit       rx_calm = 1'b0;
    int       rx_hold = 0;
    int       quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    double_ended_queue uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    deque_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .mismatches    (mismatches),
        .views_pending (views_pending)
    );

    function automatic deq_in_t make_op(logic [2:0] code, logic [WORD_W-1:0] word);
        deq_in_t it;
        it.opcode = code;
        it.value = word;
        return it;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] word;
        case ($urandom_range(0, 15))
            0: word = 32'h8000_0000;
            1: word = 32'h7fff_ffff;
            2: word = 32'h0000_0000;
            3: word = 32'hffff_ffff;
            default: word = $urandom;
        endcase
        return word;
    endfunction

    // called at a rising edge, returns at the edge where the item is taken
    task automatic send_op(deq_in_t it);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        int stall;
        stall = 0;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            if ($urandom_range(0, 31) == 0) begin
                rx_calm <= !rx_calm;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 3);
            rx_hold <= stall;
            m_ready <= (stall == 0);
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= (rx_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [WORD_W-1:0] corner_words [8];
        logic [2:0]        code;
        int                sent;
        int                burst_len;
        int                push_pct;
        corner_words = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                         32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555, 32'hfffe_0001};
        sent = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty queue corners
        send_op(make_op(OP_QUERY, 32'h1234_5678));
        send_op(make_op(OP_POP_FRONT, 32'hffff_ffff));
        send_op(make_op(OP_POP_BACK, 32'h0000_0000));
        send_op(make_op(OP_UNUSED_LO, 32'h8000_0000));
        sent += 4;

        // fill to the brim from both ends, push past it, send unused opcodes, then pop from each end
        for (int i = 0; i < DEPTH_DEFAULT; i++) begin
            send_op(make_op((i % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                            (i < 8) ? corner_words[i] : $urandom));
            sent++;
        end
        send_op(make_op(OP_PUSH_BACK, 32'hdead_beef));
        send_op(make_op(OP_PUSH_FRONT, 32'h0bad_f00d));
        send_op(make_op(OP_UNUSED_MID, 32'hffff_ffff));
        send_op(make_op(OP_UNUSED_HI, 32'h0000_0000));
        send_op(make_op(OP_POP_FRONT, 32'h0000_0000));
        send_op(make_op(OP_POP_BACK, 32'hffff_ffff));
        sent += 6;

        // bursts that lean towards filling, draining or neither
        while (sent < ITEMS) begin
            burst_len = $urandom_range(4, 40);
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 20;
                default: push_pct = 50;
            endcase
            tx_calm = ($urandom_range(0, 3) == 0);
            repeat (burst_len) begin
                if ($urandom_range(0, 99) < 6) begin
                    code = 3'($urandom_range(OP_QUERY, OP_UNUSED_HI));
                end else if ($urandom_range(0, 99) < push_pct) begin
                    code = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                end else begin
                    code = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
                end
                send_op(make_op(code, pick_word()));
                sent++;
            end
        end
        s_valid <= 1'b0;

        while (views_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
